/* src/tidt_pkg.sv */
// shared constants and codes for the table interpolator
package tidt_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;

	localparam int ABS_W = 32;
	localparam int VAL_W = 48;
	localparam int NUM_W = 88;
	localparam int DEN_W = 65;
	localparam int QUO_W = 49;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam logic [1:0] ACT_QUERY  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [2:0] ST_INTERP   = 3'd0;
	localparam logic [2:0] ST_BELOW    = 3'd1;
	localparam logic [2:0] ST_ABOVE    = 3'd2;
	localparam logic [2:0] ST_STORED   = 3'd3;
	localparam logic [2:0] ST_ORDER    = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_UNUSABLE = 3'd6;

	localparam logic [1:0] REG_LOW_W  = 2'd0;
	localparam logic [1:0] REG_LOW_G  = 2'd1;
	localparam logic [1:0] REG_HIGH_W = 2'd2;
	localparam logic [1:0] REG_HIGH_G = 2'd3;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W:0] ONE_Q24 = (VAL_W+1)'(1) << 24;
endpackage

/* src/tidt_ram.sv */
// single-port ram with registered read
module tidt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* src/table_interp_with_drude_tails_top.sv */
// table interpolator with plasma-model tails, iterative datapath
//
// channel   signals                                   handshake
// config    cfg_we cfg_index cfg_data                 write when cfg_we high
// input     action abscissa raw_value                 taken when start & !busy
// result    value status saturated                    one-cycle done strobe
//
// append, clear and trivial queries: done in the cycle after start
// interpolation: a binary search with one ram read per step, then a fetch of
// the bracketing pair, the multiply steps and the divider
// tail model: the multiply steps, then the divider, one quotient bit a cycle
// the radix-2 divider dominates the run time; reset needs no clearing pass
// the receiver cannot stall: each word is shown for one cycle only
module table_interp_with_drude_tails_top
	import tidt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              action,
	input  logic [ABS_W-1:0]        abscissa,
	input  logic signed [VAL_W-1:0] raw_value,
	output logic                    done,
	output logic signed [VAL_W-1:0] value,
	output logic [2:0]              status,
	output logic                    saturated
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRCH_A = 4'd1;
	localparam logic [3:0] S_SRCH_C = 4'd2;
	localparam logic [3:0] S_FL     = 4'd3;
	localparam logic [3:0] S_FU     = 4'd4;
	localparam logic [3:0] S_FW     = 4'd5;
	localparam logic [3:0] S_PREP   = 4'd6;
	localparam logic [3:0] S_T1     = 4'd7;
	localparam logic [3:0] S_T2     = 4'd8;
	localparam logic [3:0] S_T3     = 4'd9;
	localparam logic [3:0] S_DIV    = 4'd10;
	localparam logic [3:0] S_FIN    = 4'd11;

	logic [3:0] state_q;
	logic [ABS_W-1:0] cfg_q [4];
	logic [CNT_W-1:0] count_q;
	logic invalid_q;
	logic [ABS_W-1:0] first_abs_q, last_abs_q;
	logic signed [VAL_W-1:0] first_val_q;

	logic done_q, sat_q;
	logic [2:0] status_q;
	logic signed [VAL_W-1:0] value_q;

	logic [ABS_W-1:0] x_q, xl_q, xu_q, xd_q;
	logic signed [VAL_W-1:0] vl_q, vu_q;
	logic [QUO_W-1:0] mag_q;
	logic neg_q;
	logic [ADDR_W-1:0] lower_q, upper_q;
	logic [2:0] stat_q;

	logic [DEN_W-1:0] prod_q;
	logic [32:0] sum_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic over_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	// ram side
	logic ram_we;
	logic [ADDR_W-1:0] ram_addr, mid;
	logic [ABS_W-1:0] abs_rdata;
	logic [VAL_W-1:0] val_rdata;
	logic [VAL_W:0] app_val;
	logic [VAL_W-1:0] app_val_sat;
	logic app_sat;
	logic [CNT_W-1:0] mid_sum;

	// shared arithmetic
	logic tail;
	logic [ABS_W-1:0] w_sel, g_sel;
	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [DEN_W-1:0] mul_p;
	logic [DEN_W:0] div_r2, div_diff;
	logic div_ge;
	logic signed [VAL_W:0] d_full;
	logic signed [VAL_W:0] interp_res;

	assign tail = (stat_q != ST_INTERP);
	assign w_sel = (stat_q == ST_BELOW) ? cfg_q[REG_LOW_W] : cfg_q[REG_HIGH_W];
	assign g_sel = (stat_q == ST_BELOW) ? cfg_q[REG_LOW_G] : cfg_q[REG_HIGH_G];

	assign mid_sum = CNT_W'(lower_q) + CNT_W'(upper_q);
	assign mid = mid_sum[CNT_W-1:1];

	assign app_val = {raw_value[VAL_W-1], raw_value} - ONE_Q24;
	assign app_sat = (app_val[VAL_W:VAL_W-1] == 2'b10);
	assign app_val_sat = app_sat ? VAL_MIN : app_val[VAL_W-1:0];

	always_comb begin
		ram_we = 1'b0;
		ram_addr = count_q[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_we = start && action == ACT_APPEND && !invalid_q
					&& count_q < CNT_W'(TABLE_DEPTH)
					&& (count_q == '0 || abscissa > last_abs_q);
			end
			S_SRCH_A: ram_addr = mid;
			S_FL:     ram_addr = lower_q;
			S_FU:     ram_addr = upper_q;
			default:  ram_addr = count_q[ADDR_W-1:0];
		endcase
	end

	tidt_ram #(.WIDTH(ABS_W), .DEPTH(TABLE_DEPTH)) u_abs_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (abscissa),
		.rdata (abs_rdata)
	);

	tidt_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (app_val_sat),
		.rdata (val_rdata)
	);

	always_comb begin
		mul_a = xd_q;
		mul_b = {9'b0, mag_q[23:0]};
		if (state_q == S_T1) begin
			mul_a = tail ? w_sel : xd_q;
			mul_b = tail ? {1'b0, w_sel} : {9'b0, mag_q[23:0]};
		end else begin
			mul_a = tail ? x_q : xd_q;
			mul_b = sum_q;
		end
	end
	assign mul_p = DEN_W'(mul_a) * mul_b;

	// one restoring division step
	assign div_r2 = {rem_q, num_q[NUM_W-1]};
	assign div_ge = div_r2 >= {1'b0, den_q};
	assign div_diff = div_r2 - {1'b0, den_q};

	assign d_full = {vu_q[VAL_W-1], vu_q} - {vl_q[VAL_W-1], vl_q};
	assign interp_res = neg_q ? ({vl_q[VAL_W-1], vl_q} - $signed(quo_q))
		: ({vl_q[VAL_W-1], vl_q} + $signed(quo_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			invalid_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				cfg_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q <= abscissa;
						value_q <= '0;
						sat_q <= 1'b0;
						status_q <= ST_UNUSABLE;
						done_q <= 1'b1;
						case (action)
							ACT_QUERY: begin
								if (invalid_q || count_q == '0) begin
									status_q <= ST_UNUSABLE;
								end else if (abscissa < first_abs_q) begin
									stat_q <= ST_BELOW;
									done_q <= 1'b0;
									state_q <= S_T1;
								end else if (abscissa > last_abs_q) begin
									stat_q <= ST_ABOVE;
									done_q <= 1'b0;
									state_q <= S_T1;
								end else if (count_q == CNT_W'(1)) begin
									value_q <= first_val_q;
									status_q <= ST_INTERP;
								end else begin
									stat_q <= ST_INTERP;
									lower_q <= '0;
									upper_q <= ADDR_W'(count_q - CNT_W'(1));
									done_q <= 1'b0;
									state_q <= S_SRCH_A;
								end
							end
							ACT_APPEND: begin
								if (invalid_q) begin
									status_q <= ST_UNUSABLE;
								end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
									status_q <= ST_FULL;
								end else if (count_q != '0 && abscissa <= last_abs_q) begin
									invalid_q <= 1'b1;
									status_q <= ST_ORDER;
								end else begin
									if (count_q == '0) begin
										first_abs_q <= abscissa;
										first_val_q <= app_val_sat;
									end
									last_abs_q <= abscissa;
									count_q <= count_q + CNT_W'(1);
									sat_q <= app_sat;
									status_q <= ST_STORED;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
								invalid_q <= 1'b0;
								status_q <= ST_STORED;
							end
							default: status_q <= ST_UNUSABLE;
						endcase
					end
				end
				S_SRCH_A: begin
					if (upper_q - lower_q == ADDR_W'(1)) begin
						state_q <= S_FL;
					end else begin
						state_q <= S_SRCH_C;
					end
				end
				S_SRCH_C: begin
					// ram holds abscissa at the midpoint issued last cycle
					if (abs_rdata > x_q) begin
						upper_q <= mid;
					end else begin
						lower_q <= mid;
					end
					state_q <= S_SRCH_A;
				end
				S_FL: state_q <= S_FU;
				S_FU: begin
					xl_q <= abs_rdata;
					vl_q <= val_rdata;
					state_q <= S_FW;
				end
				S_FW: begin
					xu_q <= abs_rdata;
					vu_q <= val_rdata;
					state_q <= S_PREP;
				end
				S_PREP: begin
					xd_q <= x_q - xl_q;
					neg_q <= d_full[VAL_W];
					mag_q <= d_full[VAL_W] ? QUO_W'(-d_full) : QUO_W'(d_full);
					state_q <= S_T1;
				end
				S_T1: begin
					prod_q <= mul_p;
					sum_q <= tail ? (33'(x_q) + 33'(g_sel)) : {8'b0, mag_q[48:24]};
					quo_q <= '0;
					over_q <= 1'b0;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_T2;
				end
				S_T2: begin
					num_q <= tail ? {prod_q[63:0], 24'b0} : NUM_W'(prod_q);
					prod_q <= mul_p;
					state_q <= S_T3;
				end
				S_T3: begin
					if (tail) begin
						den_q <= prod_q;
						if (prod_q == '0) begin
							// zero divisor saturates straight away
							over_q <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						num_q <= num_q + {prod_q[63:0], 24'b0};
						den_q <= DEN_W'(xu_q - xl_q);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? div_diff[DEN_W-1:0] : div_r2[DEN_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], div_ge};
					over_q <= over_q | quo_q[QUO_W-1];
					num_q <= num_q << 1;
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					status_q <= stat_q;
					done_q <= 1'b1;
					state_q <= S_IDLE;
					if (tail) begin
						if (over_q || quo_q[QUO_W-1:QUO_W-2] != 2'b00) begin
							value_q <= VAL_MAX;
							sat_q <= 1'b1;
						end else begin
							value_q <= quo_q[VAL_W-1:0];
							sat_q <= 1'b0;
						end
					end else begin
						value_q <= interp_res[VAL_W-1:0];
						sat_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign value = value_q;
	assign status = status_q;
	assign saturated = sat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_A || state_q == S_SRCH_C) |-> lower_q < upper_q)
		else $error("search bracket collapsed");

	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_STORED || status == ST_ORDER || status == ST_FULL)
		|-> value == '0)
		else $error("non-query word carries a value");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> done && !busy)
		else $error("finished query gave no word");
endmodule
